// File: src/dipd_pkg.sv
// dipd_pkg: shared types and constants for the interlocked two-channel pwm drive
// no dependencies
package dipd_pkg;

   // command codes carried by req_kind
   typedef enum logic [1:0] {
      KIND_TICK      = 2'd0,
      KIND_SET_ACCEL = 2'd1,
      KIND_SET_DECEL = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ARG_COUNT = 2'd1,
      STATUS_RANGE     = 2'd2
   } status_type;

   localparam logic [7:0] DUTY_MAX      = 8'd100;
   localparam logic [3:0] SET_ARG_COUNT = 4'd2;

   // one result item
   typedef struct packed {
      logic       accel_pin;
      logic       decel_pin;
      status_type status;
      logic [7:0] applied_duty;
   } rsp_type;

endpackage

// File: src/dual_interlocked_pwm_drive_core.sv
// dual_interlocked_pwm_drive_core: two mutually exclusive software pwm outputs
// depends on dipd_pkg (command codes, status codes, result struct)
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   req     | req_valid/req_ready  | req_kind, req_arg_count, req_duty_request
//   rsp     | rsp_valid/rsp_ready  | rsp_accel_pin, rsp_decel_pin, rsp_status,
//           |                      | rsp_applied_duty
//
// one item per cycle while req_ready is high: the pwm state is updated at the accepting edge and the
// result lands in the output register (or the skid register) at that same edge
// reset clears duties, ramps, period counter, pins and the valid flags of both result slots
// a stalled rsp side fills the skid register; req_ready drops only while it is full
module dual_interlocked_pwm_drive_core
   import dipd_pkg::*;
#(
   parameter int DUTY_STEP    = 10,
   parameter int PERIOD_TICKS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [3:0] req_arg_count,
   input  logic [7:0] req_duty_request,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_accel_pin,
   output logic       rsp_decel_pin,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_applied_duty
);

   localparam logic [7:0] STEP     = 8'(DUTY_STEP);
   localparam logic [7:0] PERIOD   = 8'(PERIOD_TICKS);
   localparam int         TAB_SIZE = 128;

   // rounding table: request rounded up to the next multiple of the step,
   // built at elaboration; only entries up to DUTY_MAX are ever used
   logic [7:0] round_tab [TAB_SIZE];

   for (genvar i = 0; i < TAB_SIZE; i++) begin : g_round
      localparam int RV = ((i + DUTY_STEP - 1) / DUTY_STEP) * DUTY_STEP;
      assign round_tab[i] = (RV > 255) ? 8'd255 : 8'(RV);
   end

   // pwm state
   logic [7:0] accel_duty_ff, accel_duty_in;
   logic [7:0] decel_duty_ff, decel_duty_in;
   logic [7:0] accel_ramp_ff, accel_ramp_in;
   logic [7:0] decel_ramp_ff, decel_ramp_in;
   logic [7:0] period_count_ff, period_count_in;
   logic       accel_pin_ff, accel_pin_in;
   logic       decel_pin_ff, decel_pin_in;

   // result slots
   rsp_type    out_ff, skid_ff, result;
   logic       out_valid_ff, skid_valid_ff;

   logic       accept;
   logic       out_free;
   logic       wrap;
   logic [7:0] accel_base, decel_base;
   logic [8:0] accel_sum, decel_sum;
   logic [7:0] accel_step, decel_step;
   logic [7:0] rounded;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;

   // tick datapath: period wrap clears both ramps before this tick's compare
   assign wrap       = period_count_ff >= PERIOD;
   assign accel_base = wrap ? 8'd0 : accel_ramp_ff;
   assign decel_base = wrap ? 8'd0 : decel_ramp_ff;
   assign accel_sum  = {1'b0, accel_base} + {1'b0, STEP};
   assign decel_sum  = {1'b0, decel_base} + {1'b0, STEP};
   // ramp saturates at full scale
   assign accel_step = accel_sum[8] ? 8'd255 : accel_sum[7:0];
   assign decel_step = decel_sum[8] ? 8'd255 : decel_sum[7:0];

   assign rounded = round_tab[req_duty_request[6:0]];

   always_comb begin
      accel_duty_in   = accel_duty_ff;
      decel_duty_in   = decel_duty_ff;
      accel_ramp_in   = accel_ramp_ff;
      decel_ramp_in   = decel_ramp_ff;
      period_count_in = period_count_ff;
      accel_pin_in    = accel_pin_ff;
      decel_pin_in    = decel_pin_ff;
      result.status       = STATUS_OK;
      result.applied_duty = 8'd0;

      unique case (kind_type'(req_kind))
         KIND_TICK: begin
            period_count_in = (wrap ? 8'd0 : period_count_ff) + 8'd1;
            accel_pin_in    = accel_duty_ff > accel_base;
            decel_pin_in    = decel_duty_ff > decel_base;
            accel_ramp_in   = accel_pin_in ? accel_step : accel_base;
            decel_ramp_in   = decel_pin_in ? decel_step : decel_base;
         end
         KIND_SET_ACCEL, KIND_SET_DECEL: begin
            // argument count is checked before the range
            if (req_arg_count != SET_ARG_COUNT) begin
               result.status = STATUS_ARG_COUNT;
            end else if (req_duty_request > DUTY_MAX) begin
               result.status = STATUS_RANGE;
            end else begin
               result.applied_duty = rounded;
               // interlock: storing one channel's duty clears the other
               if (kind_type'(req_kind) == KIND_SET_ACCEL) begin
                  accel_duty_in = rounded;
                  decel_duty_in = 8'd0;
               end else begin
                  decel_duty_in = rounded;
                  accel_duty_in = 8'd0;
               end
            end
         end
         default: begin
            // unused code: no state change
         end
      endcase

      // pins reported after this item
      result.accel_pin = accel_pin_in;
      result.decel_pin = decel_pin_in;
   end

   // pwm state register, updated only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         accel_duty_ff   <= 8'd0;
         decel_duty_ff   <= 8'd0;
         accel_ramp_ff   <= 8'd0;
         decel_ramp_ff   <= 8'd0;
         period_count_ff <= 8'd0;
         accel_pin_ff    <= 1'b0;
         decel_pin_ff    <= 1'b0;
      end else if (accept) begin
         accel_duty_ff   <= accel_duty_in;
         decel_duty_ff   <= decel_duty_in;
         accel_ramp_ff   <= accel_ramp_in;
         decel_ramp_ff   <= decel_ramp_in;
         period_count_ff <= period_count_in;
         accel_pin_ff    <= accel_pin_in;
         decel_pin_ff    <= decel_pin_in;
      end
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            // skid drains first; no item is accepted while it is full
            out_ff        <= skid_ff;
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
            if (accept) begin
               out_ff <= result;
            end
         end
      end else if (accept) begin
         // output stalled: park the new result
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accel_pin    = out_ff.accel_pin;
   assign rsp_decel_pin    = out_ff.decel_pin;
   assign rsp_status       = out_ff.status;
   assign rsp_applied_duty = out_ff.applied_duty;

endmodule

// File: tb/testbench.sv
// testbench for dual_interlocked_pwm_drive_core: directed and random commands and ticks
// depends on dipd_pkg and the core; results are checked against an in-bench pwm predictor
module testbench;
   import dipd_pkg::*;

   localparam int DUTY_STEP      = 10;
   localparam int PERIOD_TICKS   = 10;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 8;
   // the one kind code that the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_kind;
   logic [3:0] req_arg_count;
   logic [7:0] req_duty_request;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_accel_pin;
   logic       rsp_decel_pin;
   logic [1:0] rsp_status;
   logic [7:0] rsp_applied_duty;

   // predicted pwm state
   logic [7:0] accel_duty;
   logic [7:0] decel_duty;
   logic [7:0] accel_ramp;
   logic [7:0] decel_ramp;
   logic [7:0] ticks_in_period;
   logic [1:0] pin_state;

   rsp_type pending_results[$];
   int      error_count;
   int      quiet_cycles;
   logic    req_gaps_on;
   logic    rsp_stalls_on;
   int      stall_left;

   dual_interlocked_pwm_drive_core #(
      .DUTY_STEP   (DUTY_STEP),
      .PERIOD_TICKS(PERIOD_TICKS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_arg_count   (req_arg_count),
      .req_duty_request(req_duty_request),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_accel_pin   (rsp_accel_pin),
      .rsp_decel_pin   (rsp_decel_pin),
      .rsp_status      (rsp_status),
      .rsp_applied_duty(rsp_applied_duty)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // one pwm channel on a tick: pin high and ramp up by a step while duty exceeds ramp
   function automatic logic ramp_step(input logic [7:0] duty, inout logic [7:0] ramp);
      int grown;
      if (duty <= ramp) begin
         return 1'b0;
      end
      grown = int'(ramp) + DUTY_STEP;
      ramp = (grown > 255) ? 8'd255 : grown[7:0];
      return 1'b1;
   endfunction

   // advance the predicted state by one accepted item and return the result it causes
   function automatic rsp_type pwm_predict(input logic [1:0] kind, input logic [3:0] argn,
                                           input logic [7:0] duty);
      rsp_type r;
      int      rounded;
      r.status       = STATUS_OK;
      r.applied_duty = '0;
      if (kind == KIND_TICK) begin
         // period wrap clears both ramps before this tick is counted
         if (int'(ticks_in_period) >= PERIOD_TICKS) begin
            accel_ramp      = '0;
            decel_ramp      = '0;
            ticks_in_period = '0;
         end
         ticks_in_period = ticks_in_period + 8'd1;
         pin_state[0]    = ramp_step(accel_duty, accel_ramp);
         pin_state[1]    = ramp_step(decel_duty, decel_ramp);
      end else if (kind == KIND_SET_ACCEL || kind == KIND_SET_DECEL) begin
         // argument count is checked before the range
         if (argn != SET_ARG_COUNT) begin
            r.status = STATUS_ARG_COUNT;
         end else if (duty > DUTY_MAX) begin
            r.status = STATUS_RANGE;
         end else begin
            // round up to the next multiple of the step
            if (int'(duty) % DUTY_STEP == 0) begin
               rounded = int'(duty);
            end else begin
               rounded = (int'(duty) / DUTY_STEP + 1) * DUTY_STEP;
            end
            if (rounded > 255) begin
               rounded = 255;
            end
            r.applied_duty = rounded[7:0];
            // interlock: setting one channel clears the other
            if (kind == KIND_SET_ACCEL) begin
               accel_duty = rounded[7:0];
               decel_duty = '0;
            end else begin
               decel_duty = rounded[7:0];
               accel_duty = '0;
            end
         end
      end
      // set commands and the unused kind leave the pins as they were
      r.accel_pin = pin_state[0];
      r.decel_pin = pin_state[1];
      return r;
   endfunction

   // present one item from a falling edge, hold it until accepted, then predict it
   task automatic send_item(input logic [1:0] kind, input logic [3:0] argn,
                            input logic [7:0] duty);
      @(negedge clock);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_arg_count    <= argn;
      req_duty_request <= duty;
      do begin
         @(posedge clock);
      end while (!req_ready);
      pending_results.push_back(pwm_predict(kind, argn, duty));
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_item(KIND_TICK, 4'($urandom), 8'($urandom));
   endtask

   // response side: random stall bursts while enabled
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // result checker: every accepted result against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: accel %0b decel %0b status %0d duty %0d",
                     $time, rsp_accel_pin, rsp_decel_pin, rsp_status, rsp_applied_duty);
            error_count = error_count + 1;
         end else begin
            want = pending_results.pop_front();
            if (rsp_accel_pin !== want.accel_pin) begin
               $display("%0t: accel_pin expected %0b actual %0b",
                        $time, want.accel_pin, rsp_accel_pin);
               error_count = error_count + 1;
            end
            if (rsp_decel_pin !== want.decel_pin) begin
               $display("%0t: decel_pin expected %0b actual %0b",
                        $time, want.decel_pin, rsp_decel_pin);
               error_count = error_count + 1;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count = error_count + 1;
            end
            if (rsp_applied_duty !== want.applied_duty) begin
               $display("%0t: applied_duty expected %0d actual %0d",
                        $time, want.applied_duty, rsp_applied_duty);
               error_count = error_count + 1;
            end
         end
      end
   end

   // watchdog: too many cycles in a row with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // pins low and period empty right after reset, then the ignored kind
   task automatic test_after_reset();
      send_ticks(1);
      send_item(KIND_UNUSED, 4'($urandom), 8'($urandom));
   endtask

   // bad argument counts and out-of-range duties on both channels
   task automatic test_set_rejects();
      send_item(KIND_SET_ACCEL, 4'd0, 8'd50);
      // argument count wins over the range check
      send_item(KIND_SET_ACCEL, 4'd15, 8'd255);
      send_item(KIND_SET_DECEL, 4'd3, 8'd50);
      send_item(KIND_SET_ACCEL, SET_ARG_COUNT, 8'd101);
      send_item(KIND_SET_DECEL, SET_ARG_COUNT, 8'd255);
   endtask

   // round-up to the step, exact multiples, zero and the top of the range
   task automatic test_set_rounding();
      send_item(KIND_SET_ACCEL, SET_ARG_COUNT, 8'd1);
      send_item(KIND_SET_DECEL, SET_ARG_COUNT, 8'd95);
      send_item(KIND_SET_ACCEL, SET_ARG_COUNT, 8'd0);
      send_item(KIND_SET_DECEL, SET_ARG_COUNT, DUTY_MAX);
   endtask

   // a full period plus the wrap, then the interlock handing over to the other channel
   task automatic test_pwm_period();
      send_item(KIND_SET_ACCEL, SET_ARG_COUNT, 8'd37);
      send_ticks(PERIOD_TICKS + 1);
      send_item(KIND_SET_DECEL, SET_ARG_COUNT, DUTY_MAX);
      send_ticks(2);
   endtask

   // mostly ticks between well-formed sets, with some broken commands and unused kinds
   task automatic test_random_traffic(input int count, input logic with_idling);
      int       pick;
      logic [1:0] set_kind;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            req_gaps_on   = with_idling && $urandom_range(0, 2) != 0;
            rsp_stalls_on = with_idling && $urandom_range(0, 2) != 0;
         end
         pick     = $urandom_range(0, 99);
         set_kind = $urandom_range(0, 1) ? KIND_SET_ACCEL : KIND_SET_DECEL;
         if (pick < 75) begin
            send_ticks(1);
         end else if (pick < 90) begin
            send_item(set_kind, SET_ARG_COUNT, 8'($urandom_range(0, 100)));
         end else if (pick < 95) begin
            send_item(set_kind, 4'($urandom), 8'($urandom));
         end else if (pick < 98) begin
            send_item(set_kind, SET_ARG_COUNT, 8'($urandom_range(101, 255)));
         end else begin
            send_item(KIND_UNUSED, 4'($urandom), 8'($urandom));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_TICK;
      req_arg_count    = '0;
      req_duty_request = '0;
      rsp_ready        = 1'b0;
      stall_left       = 0;
      error_count      = 0;
      quiet_cycles     = 0;
      req_gaps_on      = 1'b1;
      rsp_stalls_on    = 1'b1;
      accel_duty       = '0;
      decel_duty       = '0;
      accel_ramp       = '0;
      decel_ramp       = '0;
      ticks_in_period  = '0;
      pin_state        = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_set_rejects();
      test_set_rounding();
      test_pwm_period();
      test_random_traffic(700, 1'b1);
      // last stretch at full rate on both sides
      test_random_traffic(200, 1'b0);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // catch any stray result after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/dipd_pkg.sv
src/dual_interlocked_pwm_drive_core.sv
tb/testbench.sv
